/* rtl/mk_pkg.sv */
// shared types, constants and the character table of the morse keyer
package mk_pkg;

  localparam int unsigned TimeW       = 24;
  localparam int unsigned CharW       = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned MaxElems    = 5;
  localparam int unsigned SegW        = 4;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [CfgIdxW-1:0] RegDot    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDash   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGap    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLetter = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWord   = 3'd4;

  localparam logic [TimeW-1:0] DotReset    = 24'd500000;
  localparam logic [TimeW-1:0] DashReset   = 24'd1500000;
  localparam logic [TimeW-1:0] GapReset    = 24'd500000;
  localparam logic [TimeW-1:0] LetterReset = 24'd1500000;
  localparam logic [TimeW-1:0] WordReset   = 24'd3000000;

  // dash bit per element, first element in the top bit
  typedef struct packed {
    logic                space;
    logic [2:0]          len;
    logic [MaxElems-1:0] dash;
  } mk_desc_t;

  typedef struct packed {
    logic     known;
    mk_desc_t desc;
  } mk_class_t;

  typedef struct packed {
    logic     valid;
    mk_desc_t desc;
  } mk_push_t;

  typedef struct packed {
    logic     full;
    logic     empty;
    mk_desc_t head;
  } mk_qstat_t;

  function automatic mk_class_t mk_entry(input logic [2:0] len, input logic [4:0] dash);
    mk_class_t r;
    r.known      = 1'b1;
    r.desc.space = 1'b0;
    r.desc.len   = len;
    r.desc.dash  = dash;
    return r;
  endfunction

  function automatic mk_class_t mk_classify(input logic [CharW-1:0] ch);
    mk_class_t r;
    r = '0;
    case (ch)
      8'h20: begin
        r.known      = 1'b1;
        r.desc.space = 1'b1;
        r.desc.len   = 3'd1;
      end
      8'h61: r = mk_entry(3'd2, 5'b01000);
      8'h62: r = mk_entry(3'd4, 5'b10000);
      8'h63: r = mk_entry(3'd4, 5'b10100);
      8'h64: r = mk_entry(3'd3, 5'b10000);
      8'h65: r = mk_entry(3'd1, 5'b00000);
      8'h66: r = mk_entry(3'd4, 5'b00100);
      8'h67: r = mk_entry(3'd3, 5'b11000);
      8'h68: r = mk_entry(3'd4, 5'b00000);
      8'h69: r = mk_entry(3'd2, 5'b00000);
      8'h6a: r = mk_entry(3'd4, 5'b01110);
      8'h6b: r = mk_entry(3'd3, 5'b10100);
      8'h6c: r = mk_entry(3'd4, 5'b01000);
      8'h6d: r = mk_entry(3'd2, 5'b11000);
      8'h6e: r = mk_entry(3'd2, 5'b10000);
      8'h6f: r = mk_entry(3'd3, 5'b11100);
      8'h70: r = mk_entry(3'd4, 5'b01100);
      8'h71: r = mk_entry(3'd4, 5'b11010);
      8'h72: r = mk_entry(3'd3, 5'b01000);
      8'h73: r = mk_entry(3'd3, 5'b00000);
      8'h74: r = mk_entry(3'd1, 5'b10000);
      8'h75: r = mk_entry(3'd3, 5'b00100);
      8'h76: r = mk_entry(3'd4, 5'b00010);
      8'h77: r = mk_entry(3'd3, 5'b01100);
      8'h78: r = mk_entry(3'd4, 5'b10010);
      8'h79: r = mk_entry(3'd4, 5'b10110);
      8'h7a: r = mk_entry(3'd4, 5'b11000);
      8'h30: r = mk_entry(3'd5, 5'b11111);
      8'h31: r = mk_entry(3'd5, 5'b01111);
      8'h32: r = mk_entry(3'd5, 5'b00111);
      8'h33: r = mk_entry(3'd5, 5'b00011);
      8'h34: r = mk_entry(3'd5, 5'b00001);
      8'h35: r = mk_entry(3'd5, 5'b00000);
      8'h36: r = mk_entry(3'd5, 5'b10000);
      8'h37: r = mk_entry(3'd5, 5'b11000);
      8'h38: r = mk_entry(3'd5, 5'b11100);
      8'h39: r = mk_entry(3'd5, 5'b11110);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/morse_keyer_core.sv */
// top level of the morse keyer
// Usage: characters enter on the in channel (in_valid_i, character_i, in_stall_o)
// and leave as timed LED segments on the out channel (out_valid_o, led_lit_o,
// duration_o, last_o, out_stall_i). A transfer happens at a clock edge with
// valid high and stall low. Lower-case letters, digits and space each give
// 2*n+1 segments (n elements; space counts as one), the last marked by last_o;
// any other code is taken and gives nothing.
// A taken character is stored in the descriptor queue; the segment sequencer
// then walks its 3 to 11 segments into the output register, one segment per
// cycle unless the queue is empty or the receiver stalls. A small
// descriptor queue lets the next characters be taken while one is played.
// Timing registers are written through cfg_we_i, cfg_index_i, cfg_wdata_i;
// unused indices are ignored. The user must write them only while the block
// is idle; the block itself does not enforce this. Reset clears the queue and
// the output valid flag and restores the default timings. When the receiver
// stalls, the output holds and the queue fills; in_stall_o rises once full.
module morse_keyer_core #(
  parameter int unsigned QueueDepth = mk_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mk_pkg::TimeW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mk_pkg::CharW-1:0]   character_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       led_lit_o,
  output logic [mk_pkg::TimeW-1:0]   duration_o,
  output logic                       last_o
);

  mk_pkg::mk_push_t  push;
  mk_pkg::mk_qstat_t qstat;
  logic              pop;

  mk_front u_front (
    .in_valid_i  (in_valid_i),
    .character_i (character_i),
    .q_full_i    (qstat.full),
    .in_stall_o  (in_stall_o),
    .push_o      (push)
  );

  mk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (qstat)
  );

  mk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_i         (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_lit_o   (led_lit_o),
    .duration_o  (duration_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/mk_front.sv */
// front end: takes characters and classifies them into element descriptors
module mk_front (
  input  logic                      in_valid_i,
  input  logic [mk_pkg::CharW-1:0]  character_i,
  input  logic                      q_full_i,
  output logic                      in_stall_o,
  output mk_pkg::mk_push_t          push_o
);

  mk_pkg::mk_class_t cls;

  always_comb begin
    cls          = mk_pkg::mk_classify(character_i);
    in_stall_o   = q_full_i;
    // unknown codes are taken and dropped
    push_o.valid = in_valid_i && !q_full_i && cls.known;
    push_o.desc  = cls.desc;
  end

endmodule

/* rtl/mk_queue.sv */
// descriptor queue between the front end and the segment sequencer
module mk_queue #(
  parameter int unsigned Depth = mk_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mk_pkg::mk_push_t  push_i,
  input  logic              pop_i,
  output mk_pkg::mk_qstat_t stat_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mk_pkg::mk_desc_t  mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  always_comb begin
    stat_o.full  = (count_q == CntW'(Depth));
    stat_o.empty = (count_q == '0);
    stat_o.head  = mem_q[rd_ptr_q];
    do_push      = push_i.valid && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    count_d      = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  a_ptrs_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == CntW'(Depth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("push lost");

endmodule

/* rtl/mk_back.sv */
// back end: timing registers and the segment sequencer with its output register
module mk_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mk_pkg::TimeW-1:0]   cfg_wdata_i,
  input  mk_pkg::mk_qstat_t          q_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       led_lit_o,
  output logic [mk_pkg::TimeW-1:0]   duration_o,
  output logic                       last_o
);

  logic [mk_pkg::TimeW-1:0] dot_q, dash_q, gap_q, letter_q, word_q;
  logic [mk_pkg::SegW-1:0]  seg_q, seg_d;
  logic                     out_valid_q, out_valid_d;
  logic                     led_lit_q, led_lit_d;
  logic [mk_pkg::TimeW-1:0] duration_q, duration_d;
  logic                     last_q, last_d;
  logic                     advance, emit, final_seg;
  logic [mk_pkg::MaxElems-1:0] dash_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q    <= mk_pkg::DotReset;
      dash_q   <= mk_pkg::DashReset;
      gap_q    <= mk_pkg::GapReset;
      letter_q <= mk_pkg::LetterReset;
      word_q   <= mk_pkg::WordReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mk_pkg::RegDot:    dot_q    <= cfg_wdata_i;
        mk_pkg::RegDash:   dash_q   <= cfg_wdata_i;
        mk_pkg::RegGap:    gap_q    <= cfg_wdata_i;
        mk_pkg::RegLetter: letter_q <= cfg_wdata_i;
        mk_pkg::RegWord:   word_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    advance     = !out_valid_q || !out_stall_i;
    emit        = advance && !q_i.empty;
    final_seg   = (seg_q == {q_i.head.len, 1'b0});
    dash_sh     = q_i.head.dash << seg_q[mk_pkg::SegW-1:1];
    pop_o       = emit && final_seg;
    seg_d       = seg_q;
    out_valid_d = out_valid_q;
    led_lit_d   = led_lit_q;
    duration_d  = duration_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = emit;
    end
    if (emit) begin
      seg_d     = final_seg ? '0 : seg_q + 1'b1;
      led_lit_d = 1'b0;
      last_d    = 1'b0;
      if (final_seg) begin
        duration_d = letter_q;
        last_d     = 1'b1;
      end else if (seg_q[0]) begin
        duration_d = gap_q;
      end else if (q_i.head.space) begin
        duration_d = word_q;
      end else begin
        led_lit_d  = 1'b1;
        duration_d = dash_sh[mk_pkg::MaxElems-1] ? dash_q : dot_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    led_lit_q  <= led_lit_d;
    duration_q <= duration_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign led_lit_o   = led_lit_q;
  assign duration_o  = duration_q;
  assign last_o      = last_q;

  a_last_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> !led_lit_q)
    else $error("closing pause lit");

  a_seg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_i.empty |-> seg_q == '0)
    else $error("segment count without a character");

  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_i.empty |-> seg_q <= {q_i.head.len, 1'b0})
    else $error("segment count past character end");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && last_q)
    else $error("character retired without closing pause");

endmodule
